### rtl/core/sqg_pkg.sv
// Shared constants, types and a helper function for the SNR squelch gate.
package sqg_pkg;

    localparam int unsigned DEF_MAX_WINDOW = 256;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned MAG_W      = 15;
    localparam int unsigned WLEN_W     = 9;
    localparam int unsigned THR_W      = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned MUL_W      = 32;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd64;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd829;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_WINDOW_LEN   = 1'b0;
    localparam t_cfg_idx REG_THRESHOLD_SQ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ_NEW,
        ST_SQ_OLD,
        ST_SUM_SQ,
        ST_WQ,
        ST_THR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

    // Magnitude of a signed sample, saturated to the largest positive value.
    function automatic logic [MAG_W-1:0] f_mag(input logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] neg;
        neg = SAMPLE_W'(-s);
        if (!s[SAMPLE_W-1]) begin
            return s[MAG_W-1:0];
        end else if (neg[SAMPLE_W-1]) begin
            return {MAG_W{1'b1}};
        end else begin
            return neg[MAG_W-1:0];
        end
    endfunction

endpackage

### rtl/core/sqg_mul.sv
// Shared multiplier that walks a wide operand in 32-bit digits, one digit per cycle.
module sqg_mul #(
    parameter int unsigned AW = 47
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [AW-1:0]                i_a,
    input  logic [sqg_pkg::MUL_W-1:0]    i_b,
    output sqg_pkg::t_mul_stat           o_stat,
    output logic [AW+sqg_pkg::MUL_W-1:0] o_p
);

    localparam int unsigned DW  = sqg_pkg::MUL_W;
    localparam int unsigned NCH = (AW + DW - 1) / DW;
    localparam int unsigned AP  = NCH * DW;
    localparam int unsigned PW  = AW + DW;
    localparam int unsigned CW  = $clog2(NCH + 1);

    logic [AP-1:0]   r_a;
    logic [DW-1:0]   r_b;
    logic [PW-1:0]   r_acc;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [2*DW-1:0] digit_prod;

    assign digit_prod = {{DW{1'b0}}, r_a[AP-1 -: DW]} * {{DW{1'b0}}, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NCH);
                r_a    <= AP'(i_a);
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= (r_acc << DW) + PW'(digit_prod);
                r_a   <= r_a << DW;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_p         = r_acc;

endmodule

### rtl/core/sqg_dline.sv
// Sample delay line with write pointer, fill count and two registered aged reads.
module sqg_dline #(
    parameter int unsigned MAX_WINDOW = sqg_pkg::DEF_MAX_WINDOW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clr,
    input  logic                                i_we,
    input  logic [sqg_pkg::SAMPLE_W-1:0]        i_wdata,
    input  logic [$clog2(MAX_WINDOW+1):0]       i_age_old,
    input  logic [$clog2(MAX_WINDOW+1):0]       i_age_out,
    output logic [sqg_pkg::SAMPLE_W-1:0]        o_old,
    output logic [sqg_pkg::SAMPLE_W-1:0]        o_out
);

    localparam int unsigned DEPTH = 2 * MAX_WINDOW;
    localparam int unsigned PTW   = $clog2(DEPTH);
    localparam int unsigned FW    = $clog2(DEPTH + 1);
    localparam int unsigned CW    = PTW + 1;
    localparam int unsigned AGW   = $clog2(MAX_WINDOW + 1) + 1;

    logic [sqg_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [PTW-1:0]               r_wp;
    logic [FW-1:0]                r_fill;
    logic [sqg_pkg::SAMPLE_W-1:0] r_old_q;
    logic [sqg_pkg::SAMPLE_W-1:0] r_out_q;
    logic                         r_old_ok;
    logic                         r_out_ok;
    logic [PTW-1:0]               addr_old;
    logic [PTW-1:0]               addr_out;
    logic                         ok_old;
    logic                         ok_out;

    function automatic logic [PTW-1:0] f_addr(input logic [PTW-1:0] wp,
                                              input logic [AGW-1:0] age);
        logic [CW-1:0] raw;
        raw = CW'(wp) + CW'(DEPTH) - CW'(age);
        if (raw >= CW'(DEPTH)) begin
            raw = raw - CW'(DEPTH);
        end
        return raw[PTW-1:0];
    endfunction

    assign addr_old = f_addr(r_wp, i_age_old);
    assign addr_out = f_addr(r_wp, i_age_out);
    assign ok_old   = CW'(i_age_old) <= CW'(r_fill);
    assign ok_out   = CW'(i_age_out) <= CW'(r_fill);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[r_wp] <= i_wdata;
            r_old_q   <= mem[addr_old];
            r_out_q   <= mem[addr_out];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_wp     <= '0;
            r_fill   <= '0;
            r_old_ok <= 1'b0;
            r_out_ok <= 1'b0;
        end else if (i_we) begin
            r_old_ok <= ok_old;
            r_out_ok <= ok_out;
            if (r_wp == PTW'(DEPTH - 1)) begin
                r_wp <= '0;
            end else begin
                r_wp <= r_wp + PTW'(1);
            end
            if (r_fill != FW'(DEPTH)) begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    assign o_old = r_old_ok ? r_old_q : '0;
    assign o_out = r_out_ok ? r_out_q : '0;

endmodule

### rtl/core/snr_squelch_gate.sv
// Top level of the moving-window SNR squelch gate with its sequencer and datapath.
//
//  Channel   Direction  Width  Contents
//  s_axis    in         16     tdata[15:0] = sample_in (signed)
//  m_axis    out        16     tdata[15:0] = sample_out (signed)
//  cfg       in         1+16   index 0 = window_len[8:0], index 1 = threshold_sq[15:0]
//
// N = ceil((30 + 2*clog2(MAX_WINDOW+1)) / 32) is the number of 32-bit digits the shared
// multiplier walks for each product of a sample.
// When the sum or the variance term is zero the threshold product is skipped.
// The up to five products of each sample run one after another through the one multiplier.
// Reset is synchronous and active low; any configuration write also clears the statistics,
// the hold count and the delay line. A stalled output holds the sequencer in its last state.
module snr_squelch_gate #(
    parameter int unsigned MAX_WINDOW = sqg_pkg::DEF_MAX_WINDOW
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [sqg_pkg::SAMPLE_W-1:0]         s_axis_tdata,   // [15:0] sample_in
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [sqg_pkg::SAMPLE_W-1:0]         m_axis_tdata,   // [15:0] sample_out
    input  logic                                 i_cfg_we,
    input  logic [sqg_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [sqg_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int unsigned MAG_W = sqg_pkg::MAG_W;
    localparam int unsigned WW    = $clog2(MAX_WINDOW + 1);
    localparam int unsigned SW    = MAG_W + WW;
    localparam int unsigned QW    = 2 * MAG_W + WW;
    localparam int unsigned VW    = QW + WW;
    localparam int unsigned PW    = VW + sqg_pkg::MUL_W;

    sqg_pkg::t_state                r_state;
    sqg_pkg::t_state                n_state;
    logic [sqg_pkg::WLEN_W-1:0]     r_wlen;
    logic [sqg_pkg::THR_W-1:0]      r_thr;
    logic [WW-1:0]                  w_eff;
    logic [MAG_W-1:0]               r_mn;
    logic [MAG_W-1:0]               r_mo;
    logic [SW-1:0]                  r_sum;
    logic [QW-1:0]                  r_sq;
    logic [VW-1:0]                  r_s2;
    logic [VW-1:0]                  r_var;
    logic [WW:0]                    r_hold;
    logic                           r_ovalid;
    logic [sqg_pkg::SAMPLE_W-1:0]   r_odata;
    logic                           accept;
    logic                           mul_start;
    logic [VW-1:0]                  mul_a;
    logic [sqg_pkg::MUL_W-1:0]      mul_b;
    sqg_pkg::t_mul_stat             mul_stat;
    logic [PW-1:0]                  mul_p;
    logic [VW-1:0]                  wq;
    logic                           out_free;
    logic                           out_load;
    logic                           trig_cmp;
    logic [WW:0]                    age_old;
    logic [WW:0]                    age_out;
    logic [sqg_pkg::SAMPLE_W-1:0]   dl_old;
    logic [sqg_pkg::SAMPLE_W-1:0]   dl_out;

    always_comb begin
        if (r_wlen == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_wlen) > MAX_WINDOW) begin
            w_eff = WW'(MAX_WINDOW);
        end else begin
            w_eff = WW'(r_wlen);
        end
    end

    assign age_old  = (WW + 1)'(w_eff);
    assign age_out  = {w_eff, 1'b0} - (WW + 1)'(1);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign out_load = !i_cfg_we && (r_state == sqg_pkg::ST_OUT) && (r_hold != '0) && out_free;
    assign wq       = VW'(mul_p);
    assign trig_cmp = PW'({r_s2, 8'h00}) > mul_p;

    sqg_dline #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_dline (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (i_cfg_we),
        .i_we      (accept),
        .i_wdata   (s_axis_tdata),
        .i_age_old (age_old),
        .i_age_out (age_out),
        .o_old     (dl_old),
        .o_out     (dl_out)
    );

    sqg_mul #(
        .AW(VW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_stat  (mul_stat),
        .o_p     (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (r_state)
            sqg_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = sqg_pkg::ST_READ;
                end
            end
            sqg_pkg::ST_READ: begin
                n_state = sqg_pkg::ST_SQ_NEW;
            end
            sqg_pkg::ST_SQ_NEW: begin
                mul_a     = VW'(r_mn);
                mul_b     = sqg_pkg::MUL_W'(r_mn);
                mul_start = !mul_stat.busy && !mul_stat.done;
                if (mul_stat.done) begin
                    n_state = sqg_pkg::ST_SQ_OLD;
                end
            end
            sqg_pkg::ST_SQ_OLD: begin
                mul_a     = VW'(r_mo);
                mul_b     = sqg_pkg::MUL_W'(r_mo);
                mul_start = !mul_stat.busy && !mul_stat.done;
                if (mul_stat.done) begin
                    n_state = sqg_pkg::ST_SUM_SQ;
                end
            end
            sqg_pkg::ST_SUM_SQ: begin
                mul_a     = VW'(r_sum);
                mul_b     = sqg_pkg::MUL_W'(r_sum);
                mul_start = !mul_stat.busy && !mul_stat.done;
                if (mul_stat.done) begin
                    n_state = sqg_pkg::ST_WQ;
                end
            end
            sqg_pkg::ST_WQ: begin
                mul_a     = VW'(r_sq);
                mul_b     = sqg_pkg::MUL_W'(w_eff);
                mul_start = !mul_stat.busy && !mul_stat.done;
                if (mul_stat.done) begin
                    n_state = sqg_pkg::ST_THR;
                end
            end
            sqg_pkg::ST_THR: begin
                mul_a = r_var;
                mul_b = sqg_pkg::MUL_W'(r_thr);
                if (r_sum == '0 || r_var == '0) begin
                    n_state = sqg_pkg::ST_OUT;
                end else begin
                    mul_start = !mul_stat.busy && !mul_stat.done;
                    if (mul_stat.done) begin
                        n_state = sqg_pkg::ST_OUT;
                    end
                end
            end
            sqg_pkg::ST_OUT: begin
                if (r_hold == '0 || out_free) begin
                    n_state = sqg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sqg_pkg::ST_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_state = sqg_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen   <= sqg_pkg::WLEN_RESET;
            r_thr    <= sqg_pkg::THR_RESET;
            r_sum    <= '0;
            r_sq     <= '0;
            r_hold   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sqg_pkg::REG_WINDOW_LEN:   r_wlen <= i_cfg_data[sqg_pkg::WLEN_W-1:0];
                    sqg_pkg::REG_THRESHOLD_SQ: r_thr  <= i_cfg_data[sqg_pkg::THR_W-1:0];
                endcase
                r_sum  <= '0;
                r_sq   <= '0;
                r_hold <= '0;
            end else begin
                unique case (r_state)
                    sqg_pkg::ST_IDLE: begin
                        if (accept) begin
                            r_mn <= sqg_pkg::f_mag(s_axis_tdata);
                        end
                    end
                    sqg_pkg::ST_READ: begin
                        r_mo  <= sqg_pkg::f_mag(dl_old);
                        r_sum <= SW'(({1'b0, r_sum} + (SW + 1)'(r_mn))
                                     - (SW + 1)'(sqg_pkg::f_mag(dl_old)));
                    end
                    sqg_pkg::ST_SQ_NEW: begin
                        if (mul_stat.done) begin
                            r_sq <= r_sq + QW'(mul_p);
                        end
                    end
                    sqg_pkg::ST_SQ_OLD: begin
                        if (mul_stat.done) begin
                            r_sq <= r_sq - QW'(mul_p);
                        end
                    end
                    sqg_pkg::ST_SUM_SQ: begin
                        if (mul_stat.done) begin
                            r_s2 <= VW'(mul_p);
                        end
                    end
                    sqg_pkg::ST_WQ: begin
                        if (mul_stat.done) begin
                            r_var <= (wq > r_s2) ? (wq - r_s2) : '0;
                        end
                    end
                    sqg_pkg::ST_THR: begin
                        if (r_sum != '0) begin
                            if (r_var == '0) begin
                                r_hold <= {w_eff, 1'b0};
                            end else if (mul_stat.done && trig_cmp) begin
                                r_hold <= {w_eff, 1'b0};
                            end
                        end
                    end
                    sqg_pkg::ST_OUT: begin
                        if (r_hold != '0 && out_free) begin
                            r_odata  <= dl_out;
                            r_hold   <= r_hold - (WW + 1)'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

### tb/snr_squelch_gate_tb.sv
// Self-checking testbench for the SNR squelch gate with a built-in predictor of its gating.
`timescale 1ns / 100ps

module snr_squelch_gate_tb;
    import sqg_pkg::*;

    localparam int unsigned DL_DEPTH       = 2 * DEF_MAX_WINDOW;
    localparam int unsigned SETTLE_CYCLES  = 600;
    localparam int unsigned DRAIN_CYCLES   = 64;
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned N_ROWS         = 28;
    localparam int unsigned N_PHASES       = 10;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_MODEL,
        ROW_NONE,
        ROW_GIVES
    } t_row_kind;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef enum logic [1:0] {
        SEG_TONE,
        SEG_NOISE,
        SEG_QUIET,
        SEG_CORNER
    } t_seg_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    idx;
        logic [15:0] value;
        logic [15:0] result;
    } t_row;

    typedef struct packed {
        logic [8:0]  win;
        logic [15:0] thr;
        t_idle_mode  mode;
        logic [9:0]  items;
        logic        holdoff;
    } t_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;   // [15:0] sample_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_axis_tdata;   // [15:0] sample_out
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predictor state.
    logic [15:0]       dl_mem [DL_DEPTH];
    logic [8:0]        dl_wr;
    longint unsigned   mag_acc;
    longint unsigned   sq_acc;
    int unsigned       open_left;
    logic [8:0]        cfg_window;
    logic [15:0]       cfg_thresh;
    logic [15:0]       gated_samples [$];

    t_idle_mode  idle_mode = IDLE_NONE;
    int unsigned holdoff_asked = 0;
    int unsigned holdoff_seen = 0;
    int unsigned holdoff_left = 0;
    int unsigned mismatches = 0;

    t_seg_kind   seg_kind = SEG_QUIET;
    int unsigned seg_left = 0;
    int unsigned seg_amp = 1;
    int unsigned seg_jit = 0;

    t_row directed_rows [N_ROWS] = '{
        '{ROW_NONE,  REG_WINDOW_LEN,   16'h0000, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'h7FFF, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'h8001, 16'h0000},
        '{ROW_CFG,   REG_WINDOW_LEN,   16'hFE00, 16'h0000},
        '{ROW_GIVES, REG_WINDOW_LEN,   16'h7FFF, 16'h0000},
        '{ROW_GIVES, REG_WINDOW_LEN,   16'h0000, 16'h7FFF},
        '{ROW_GIVES, REG_WINDOW_LEN,   16'h8000, 16'h0000},
        '{ROW_GIVES, REG_WINDOW_LEN,   16'h0000, 16'h8000},
        '{ROW_NONE,  REG_WINDOW_LEN,   16'h0000, 16'h0000},
        '{ROW_GIVES, REG_WINDOW_LEN,   16'hFFFF, 16'h0000},
        '{ROW_GIVES, REG_WINDOW_LEN,   16'h0001, 16'hFFFF},
        '{ROW_GIVES, REG_WINDOW_LEN,   16'h0000, 16'h0001},
        '{ROW_CFG,   REG_WINDOW_LEN,   16'h01FF, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'h4000, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'hC000, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'h7FFF, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'h8000, 16'h0000},
        '{ROW_CFG,   REG_THRESHOLD_SQ, 16'h0000, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'h0005, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'hAAAA, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'h5555, 16'h0000},
        '{ROW_CFG,   REG_THRESHOLD_SQ, 16'hFFFF, 16'h0000},
        '{ROW_CFG,   REG_WINDOW_LEN,   16'h0002, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'h1234, 16'h0000},
        '{ROW_GIVES, REG_WINDOW_LEN,   16'hEDCC, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'h1234, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'h1234, 16'h0000},
        '{ROW_MODEL, REG_WINDOW_LEN,   16'h0000, 16'h0000}
    };

    t_phase phases [N_PHASES] = '{
        '{9'd64,  16'd829,   IDLE_NONE,     10'd110, 1'b0},
        '{9'd1,   16'd0,     IDLE_NONE,     10'd90,  1'b1},
        '{9'd16,  16'd256,   IDLE_RECEIVER, 10'd100, 1'b0},
        '{9'd256, 16'hFFFF,  IDLE_BOTH,     10'd70,  1'b0},
        '{9'd3,   16'd829,   IDLE_SENDER,   10'd100, 1'b0},
        '{9'd8,   16'd4000,  IDLE_SENDER,   10'd100, 1'b0},
        '{9'd32,  16'd100,   IDLE_RECEIVER, 10'd110, 1'b0},
        '{9'd256, 16'd0,     IDLE_NONE,     10'd80,  1'b0},
        '{9'd5,   16'd12345, IDLE_BOTH,     10'd100, 1'b0},
        '{9'd2,   16'd600,   IDLE_RECEIVER, 10'd90,  1'b0}
    };

    snr_squelch_gate i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned eff_window(logic [8:0] raw);
        if (raw == 9'd0) begin
            return 1;
        end else if (raw > 9'(DEF_MAX_WINDOW)) begin
            return DEF_MAX_WINDOW;
        end
        return 32'(raw);
    endfunction

    function automatic longint unsigned sat_mag(logic [15:0] raw);
        logic [15:0] neg;
        neg = -raw;
        if (raw == 16'h8000) begin
            return 32767;
        end else if (raw[15]) begin
            return 64'(neg);
        end
        return 64'(raw);
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < DL_DEPTH; i++) begin
            dl_mem[i] = 16'h0000;
        end
        dl_wr = 9'd0;
        mag_acc = 0;
        sq_acc = 0;
        open_left = 0;
    endfunction

    // Advances the gate by one sample; returns 1 with the passed sample when the gate is open.
    function automatic bit squelch_step(input logic [15:0] smp, output logic [15:0] passed);
        int unsigned     w;
        logic [8:0]      old_idx;
        logic [8:0]      out_idx;
        longint unsigned m_new, m_old, s2, wq, spread;
        logic [127:0]    lhs, rhs;
        bit              fire;
        w = eff_window(cfg_window);
        fire = 1'b0;
        passed = 16'h0000;
        dl_mem[dl_wr] = smp;
        old_idx = dl_wr - 9'(w);
        m_new = sat_mag(smp);
        m_old = sat_mag(dl_mem[old_idx]);
        mag_acc = mag_acc + m_new - m_old;
        sq_acc = sq_acc + m_new * m_new - m_old * m_old;
        if (mag_acc != 0) begin
            s2 = mag_acc * mag_acc;
            wq = longint'(w) * sq_acc;
            spread = (wq > s2) ? wq - s2 : 0;
            if (spread == 0) begin
                fire = 1'b1;
            end else begin
                rhs = 128'(cfg_thresh) * 128'(spread);
                lhs = 128'(s2) << 8;
                fire = (lhs > rhs);
            end
        end
        if (fire) begin
            open_left = 2 * w;
        end
        dl_wr = dl_wr + 9'd1;
        if (open_left != 0) begin
            out_idx = dl_wr - 9'd1 - 9'(2 * w - 1);
            passed = dl_mem[out_idx];
            open_left--;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Bursts of near-constant magnitude open the gate; noise, silence and corner values break them.
    function automatic logic [15:0] draw_sample(int unsigned w);
        int unsigned pick;
        logic [15:0] mag;
        if (seg_left == 0) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                seg_kind = SEG_TONE;
            end else if (pick < 80) begin
                seg_kind = SEG_NOISE;
            end else if (pick < 90) begin
                seg_kind = SEG_QUIET;
            end else begin
                seg_kind = SEG_CORNER;
            end
            seg_left = $urandom_range(2 * w + 8, 1);
            seg_amp = $urandom_range(32767, 1);
            seg_jit = ($urandom_range(3) == 0) ? 0 : $urandom_range(seg_amp / 32, 0);
        end
        seg_left--;
        case (seg_kind)
            SEG_TONE: begin
                mag = 16'(seg_amp - $urandom_range(seg_jit, 0));
                if ($urandom_range(1) == 1) begin
                    mag = -mag;
                end
                return mag;
            end
            SEG_NOISE: return 16'($urandom);
            SEG_QUIET: return 16'h0000;
            default: begin
                pick = $urandom_range(4);
                case (pick)
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0001;
                    3: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 30) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    task automatic check_output(input logic [15:0] got);
        logic [15:0] want;
        if (gated_samples.size() == 0) begin
            report_mismatch($sformatf("sample_out %h with no request pending", got));
        end else begin
            want = gated_samples.pop_front();
            if (got !== want) begin
                report_mismatch($sformatf("sample_out %h, predicted %h", got, want));
            end
        end
    endtask

    task automatic offer_sample(input logic [15:0] smp);
        int unsigned pct;
        pct = (idle_mode == IDLE_SENDER) ? 81 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        while ($urandom_range(99) < pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_and_predict(input logic [15:0] smp);
        logic [15:0] passed;
        offer_sample(smp);
        if (squelch_step(smp, passed)) begin
            gated_samples.push_back(passed);
        end
    endtask

    // The pause covers the latency of the last request.
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        while (gated_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WINDOW_LEN) begin
            cfg_window = value[8:0];
        end else begin
            cfg_thresh = value;
        end
        clear_model();
    endtask

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            check_output(m_axis_tdata);
        end
        if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holdoff_seen != holdoff_asked) begin
            holdoff_seen <= holdoff_asked;
            holdoff_left <= HOLDOFF_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECEIVER: m_axis_tready <= ($urandom_range(99) >= 81);
                IDLE_BOTH:     m_axis_tready <= ($urandom_range(99) >= 6);
                default:       m_axis_tready <= 1'b1;
            endcase
        end
    end

    initial begin
        logic [15:0] passed;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_WINDOW_LEN;
        i_cfg_data = '0;
        cfg_window = WLEN_RESET;
        cfg_thresh = THR_RESET;
        clear_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            case (directed_rows[r].kind)
                ROW_CFG: write_reg(directed_rows[r].idx, directed_rows[r].value);
                ROW_MODEL: send_and_predict(directed_rows[r].value);
                default: begin
                    offer_sample(directed_rows[r].value);
                    void'(squelch_step(directed_rows[r].value, passed));
                    if (directed_rows[r].kind == ROW_GIVES) begin
                        gated_samples.push_back(directed_rows[r].result);
                    end
                end
            endcase
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(REG_WINDOW_LEN, 16'(phases[p].win));
            write_reg(REG_THRESHOLD_SQ, phases[p].thr);
            idle_mode <= phases[p].mode;
            seg_left = 0;
            if (phases[p].holdoff) begin
                holdoff_asked <= holdoff_asked + 1;
            end
            for (int n = 0; n < phases[p].items; n++) begin
                send_and_predict(draw_sample(eff_window(phases[p].win)));
            end
        end

        s_axis_tvalid <= 1'b0;
        idle_mode <= IDLE_NONE;
        while (gated_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("snr_squelch_gate: match");
        end else begin
            $display("snr_squelch_gate: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("snr_squelch_gate: mismatch");
        $finish;
    end

endmodule
